[rtl/bsq_pkg.sv]
`timescale 1ns / 1ps
package bsq_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_LOWEST  = 3'd1,
        ACT_HIGHEST = 3'd2,
        ACT_LAST    = 3'd3,
        ACT_FIRST   = 3'd4,
        ACT_LBOUND  = 3'd5
    } t_action;

    localparam logic [2:0] CMP_GE = 3'd0;
    localparam logic [2:0] CMP_LE = 3'd1;
    localparam logic [2:0] CMP_EQ = 3'd2;
    localparam logic [2:0] CMP_GT = 3'd3;
    localparam logic [2:0] CMP_LT = 3'd4;

    localparam logic [1:0] ATTR_OPEN  = 2'd0;
    localparam logic [1:0] ATTR_CLOSE = 2'd1;
    localparam logic [1:0] ATTR_HIGH  = 2'd2;
    localparam logic [1:0] ATTR_LOW   = 2'd3;

    localparam int DATE_W = 27;
    localparam int TIME_W = 18;
    localparam int IDX_W  = 10;
    localparam int RES_W  = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic setup;
        logic read;
        logic eval;
        logic load;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic finished;
    } t_status;

endpackage

[rtl/bar_series_query_engine_core.sv]
// Bar series query engine.
// Slave channel: one request per beat. s_tuser carries the action and s_tdata
// the remaining request fields. A load request stores one bar and the other
// requests search the stored bars.
// Master channel: one result per request; m_tdata holds result_index and
// m_tuser holds found.
// i_cfg_we with i_cfg_data sets bar_count; write it only while idle.
// A load result is valid in the cycle after the request is accepted.
// After ST_SETUP, a range or match search reads one bar in ST_READ and compares
// it in ST_EVAL, bar after bar, until the search finishes; then ST_DONE.
// A lower-bound search also alternates ST_READ and ST_EVAL, halving the range,
// with at most log2(range) + 1 bars probed.
// Requests are handled one at a time; s_tready is high only while idle, so the
// next request is taken no earlier than the cycle after a result is accepted.
// When the receiver stalls, the result holds on the master side and no new
// request is taken. Reset clears bar_count and the controller; bar contents
// are undefined until loaded.
`timescale 1ns / 1ps
module bar_series_query_engine_core #(
    parameter int MAX_BARS    = 1024,
    parameter int PRICE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bar_index, range end, bar_date, bar_time, open, high, low and close
    // prices, attribute, comparison, threshold, zero filled
    input  logic [231:0] s_tdata,
    // action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_index (11 bits, signed), zero filled
    output logic [15:0]  m_tdata,
    // found
    output logic         m_tuser,
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_data
);
    import bsq_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_idle;
    logic    w_start;
    logic [RES_W-1:0] w_result;

    assign w_start = s_tvalid && w_idle;
    assign s_tready = w_idle;

    bsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_is_load   (s_tuser == ACT_LOAD),
        .i_out_taken (m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_out_valid (m_tvalid)
    );

    bsq_datapath #(
        .MAX_BARS    (MAX_BARS),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_action     (s_tuser),
        .i_bar_index  (s_tdata[9:0]),
        .i_range_end  (s_tdata[19:10]),
        .i_bar_date   (s_tdata[46:20]),
        .i_bar_time   (s_tdata[64:47]),
        .i_px_open    (s_tdata[96:65]),
        .i_px_high    (s_tdata[128:97]),
        .i_px_low     (s_tdata[160:129]),
        .i_px_close   (s_tdata[192:161]),
        .i_attribute  (s_tdata[194:193]),
        .i_comparison (s_tdata[197:195]),
        .i_threshold  (s_tdata[229:198]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_status     (w_status),
        .o_result     (w_result)
    );

    assign m_tdata = {5'b0, w_result};
    assign m_tuser = ~w_result[RES_W-1];

endmodule

[rtl/bsq_ctrl.sv]
`timescale 1ns / 1ps
module bsq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_is_load,
    input  logic             i_out_taken,
    input  bsq_pkg::t_status i_status,
    output bsq_pkg::t_cmd    o_cmd,
    output logic             o_idle,
    output logic             o_out_valid
);
    import bsq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = i_is_load ? ST_DONE : ST_SETUP;
            end
            ST_SETUP: n_state = ST_READ;
            ST_READ: begin
                n_state = i_status.finished ? ST_DONE : ST_EVAL;
            end
            ST_EVAL:  n_state = ST_READ;
            ST_DONE: begin
                if (i_out_taken) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_idle      = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle     = 1'b1;
                o_cmd.load = i_start;
            end
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_READ:  o_cmd.read  = 1'b1;
            ST_EVAL:  o_cmd.eval  = 1'b1;
            ST_DONE: begin
                o_out_valid = 1'b1;
                o_cmd.done  = 1'b1;
            end
            default: o_idle = 1'b0;
        endcase
    end

    property p_done_holds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_DONE && !i_out_taken) |=> (r_state == ST_DONE);
    endproperty
    a_done_holds: assert property (p_done_holds) else $error("result dropped");

    property p_eval_after_read;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_READ && !i_status.finished) |=> (r_state == ST_EVAL);
    endproperty
    a_eval_after_read: assert property (p_eval_after_read) else $error("read not evaluated");

    property p_no_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != ST_IDLE) |-> !o_cmd.load;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

endmodule

[rtl/bsq_datapath.sv]
`timescale 1ns / 1ps
module bsq_datapath #(
    parameter int MAX_BARS    = 1024,
    parameter int PRICE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsq_pkg::t_cmd                i_cmd,
    input  logic [2:0]                   i_action,
    input  logic [bsq_pkg::IDX_W-1:0]    i_bar_index,
    input  logic [bsq_pkg::IDX_W-1:0]    i_range_end,
    input  logic [bsq_pkg::DATE_W-1:0]   i_bar_date,
    input  logic [bsq_pkg::TIME_W-1:0]   i_bar_time,
    input  logic [31:0]                  i_px_open,
    input  logic [31:0]                  i_px_high,
    input  logic [31:0]                  i_px_low,
    input  logic [31:0]                  i_px_close,
    input  logic [1:0]                   i_attribute,
    input  logic [2:0]                   i_comparison,
    input  logic [31:0]                  i_threshold,
    input  logic                         i_cfg_we,
    input  logic [bsq_pkg::RES_W-1:0]    i_cfg_data,
    output bsq_pkg::t_status             o_status,
    output logic [bsq_pkg::RES_W-1:0]    o_result
);
    import bsq_pkg::*;

    localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CW = 18;
    localparam int PW = PRICE_WIDTH;
    localparam int TW = (PW > 32) ? PW : 32;
    localparam int DW = DATE_W + TIME_W + 4 * PW;

    logic [DW-1:0] r_mem [MAX_BARS];
    logic [DW-1:0] r_rdata;

    logic [CW-1:0] r_count;
    logic [2:0]    r_act;
    logic [CW-1:0] r_lo, r_hi, r_cur;
    logic [CW-1:0] r_left, r_right;
    logic [CW:0]   r_res;
    logic [DATE_W-1:0] r_date;
    logic [TIME_W-1:0] r_time;
    logic [1:0]    r_attr;
    logic [2:0]    r_cmp;
    logic [31:0]   r_thr;
    logic [PW-1:0] r_bestval;
    logic          r_first;
    logic          r_fin;

    logic [CW-1:0] w_n, w_s, w_e, w_nm1, w_mn, w_mx;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [AW-1:0] w_raddr;
    logic [DATE_W-1:0] w_rd_date;
    logic [TIME_W-1:0] w_rd_time;
    logic [PW-1:0] w_ro, w_rh, w_rl, w_rc, w_pick;
    logic [TW-1:0] w_pv, w_tv;
    logic          w_pass;
    logic          w_before, w_after;

    assign w_n   = (r_count > CW'(MAX_BARS)) ? CW'(MAX_BARS) : r_count;
    assign w_nm1 = w_n - CW'(1);
    assign w_s   = CW'(i_bar_index);
    assign w_e   = CW'(i_range_end);
    assign w_mn  = (w_s < w_e) ? w_s : w_e;
    assign w_mx  = (w_s < w_e) ? w_e : w_s;
    assign w_sum = {1'b0, r_left} + {1'b0, r_right};
    assign w_mid = w_sum[CW:1];

    assign {w_rd_date, w_rd_time, w_ro, w_rh, w_rl, w_rc} = r_rdata;

    always_comb begin
        case (r_attr)
            ATTR_OPEN:  w_pick = w_ro;
            ATTR_CLOSE: w_pick = w_rc;
            ATTR_HIGH:  w_pick = w_rh;
            default:    w_pick = w_rl;
        endcase
    end

    assign w_pv = TW'(w_pick);
    assign w_tv = TW'(r_thr);

    always_comb begin
        case (r_cmp)
            CMP_GE:  w_pass = w_pv >= w_tv;
            CMP_LE:  w_pass = w_pv <= w_tv;
            CMP_EQ:  w_pass = w_pv == w_tv;
            CMP_GT:  w_pass = w_pv > w_tv;
            CMP_LT:  w_pass = w_pv < w_tv;
            default: w_pass = 1'b0;
        endcase
    end

    assign w_before = (w_rd_date < r_date) || (w_rd_date == r_date && w_rd_time < r_time);
    assign w_after  = (w_rd_date > r_date) || (w_rd_date == r_date && w_rd_time > r_time);

    always_comb begin
        if (r_act == ACT_LBOUND) begin
            w_raddr = w_mid[AW-1:0];
        end else begin
            w_raddr = r_cur[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_action == ACT_LOAD && w_s < CW'(MAX_BARS)) begin
            r_mem[w_s[AW-1:0]] <= {i_bar_date, i_bar_time, PW'(i_px_open),
                                   PW'(i_px_high), PW'(i_px_low), PW'(i_px_close)};
        end
        if (i_cmd.read) r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= CW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
            r_res <= '1;
        end else if (i_cmd.load) begin
            r_act  <= i_action;
            r_date <= i_bar_date;
            r_time <= i_bar_time;
            r_attr <= i_attribute;
            r_cmp  <= i_comparison;
            r_thr  <= i_threshold;
            r_fin  <= 1'b0;
            r_res  <= (i_action == ACT_LOAD && w_s < CW'(MAX_BARS)) ? {1'b0, w_s} : '1;
            r_first <= 1'b1;
            case (i_action)
                ACT_LOWEST, ACT_HIGHEST: begin
                    r_lo <= w_mn;
                    r_hi <= (w_mx > w_nm1 || w_n == '0) ? w_nm1 : w_mx;
                end
                ACT_LAST: begin
                    r_lo <= '0;
                    r_hi <= w_s;
                end
                default: begin
                    r_lo <= w_s;
                    r_hi <= (w_e > w_nm1) ? w_nm1 : w_e;
                end
            endcase
        end else if (i_cmd.setup) begin
            r_left  <= r_lo;
            r_right <= r_hi;
            r_cur   <= (r_act == ACT_LAST) ? r_hi : r_lo;
            if (r_act == ACT_LOWEST || r_act == ACT_HIGHEST) begin
                r_fin <= (w_n == '0) || (r_lo > r_hi);
            end else if (r_act == ACT_LAST || r_act == ACT_FIRST || r_act == ACT_LBOUND) begin
                r_fin <= (r_act == ACT_LAST) ? (r_hi >= w_n)
                         : ((r_lo >= w_n) || (r_lo > r_hi));
            end else begin
                r_fin <= 1'b1;
            end
        end else if (i_cmd.eval) begin
            unique case (r_act)
                ACT_LOWEST, ACT_HIGHEST: begin
                    if (r_first || (r_act == ACT_LOWEST ? (w_rl < r_bestval)
                                                         : (w_rh > r_bestval))) begin
                        r_bestval <= (r_act == ACT_LOWEST) ? w_rl : w_rh;
                        r_res     <= {1'b0, r_cur};
                    end
                    r_first <= 1'b0;
                    r_cur   <= r_cur + CW'(1);
                    r_fin   <= (r_cur == r_hi);
                end
                ACT_LAST: begin
                    if (w_pass) begin
                        r_res <= {1'b0, r_cur};
                        r_fin <= 1'b1;
                    end else begin
                        r_cur <= r_cur - CW'(1);
                        r_fin <= (r_cur == '0);
                    end
                end
                ACT_FIRST: begin
                    if (w_pass) begin
                        r_res <= {1'b0, r_cur};
                        r_fin <= 1'b1;
                    end else begin
                        r_cur <= r_cur + CW'(1);
                        r_fin <= (r_cur == r_hi);
                    end
                end
                ACT_LBOUND: begin
                    if (w_before) begin
                        r_left <= w_mid + CW'(1);
                        r_fin  <= (w_mid + CW'(1) > r_right);
                    end else if (w_after) begin
                        r_res   <= {1'b0, w_mid};
                        r_right <= w_mid - CW'(1);
                        r_fin   <= (w_mid == '0) || (w_mid - CW'(1) < r_left);
                    end else begin
                        r_res <= {1'b0, w_mid};
                        r_fin <= 1'b1;
                    end
                end
                default: r_fin <= 1'b1;
            endcase
        end
    end

    assign o_status.finished = r_fin;
    assign o_result = RES_W'(r_res);

    property p_res_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.done && o_result[RES_W-1] == 1'b0) |-> (o_result < RES_W'(MAX_BARS));
    endproperty
    a_res_in_range: assert property (p_res_in_range) else $error("index out of range");

    property p_fin_on_done;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.done && r_act != ACT_LOAD) |-> r_fin;
    endproperty
    a_fin_on_done: assert property (p_fin_on_done) else $error("result before finish");

    property p_count_stable;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.eval && !i_cfg_we) |=> $stable(r_count);
    endproperty
    a_count_stable: assert property (p_count_stable) else $error("count changed");

endmodule
